[rtl/core/assert_macros.svh]
// Assertion macros shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH

// Property holds at every clock edge outside reset.
`define ASSERT_ALWAYS(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) \
        else $error("%m: assertion failed");

// Consequent holds in the cycle after the antecedent.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("%m: assertion failed");

`else

`define ASSERT_ALWAYS(lbl, clk, rst_n, prop)
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

[rtl/core/bsf_pkg.sv]
package bsf_pkg;

    typedef enum logic [2:0] {
        ST_IDLE         = 3'd0,
        ST_CONNECT      = 3'd1,
        ST_ACTIVE       = 3'd2,
        ST_OPEN_SENT    = 3'd3,
        ST_OPEN_CONFIRM = 3'd4,
        ST_ESTABLISHED  = 3'd5
    } t_state;

    typedef enum logic [3:0] {
        ACT_IGNORE          = 4'd0,
        ACT_START_CONNECT   = 4'd1,
        ACT_STOP            = 4'd2,
        ACT_STOP_ERROR      = 4'd3,
        ACT_CONNECT_SUCCESS = 4'd4,
        ACT_CONNECT_FAIL    = 4'd5,
        ACT_RECONNECT       = 4'd6,
        ACT_OPEN_RECEIVED   = 4'd7,
        ACT_ESTABLISH       = 4'd8,
        ACT_SEND_KEEPALIVE  = 4'd9,
        ACT_HOLD_EXPIRE     = 4'd10,
        ACT_KEEPALIVE_RX    = 4'd11,
        ACT_UPDATE_RX       = 4'd12
    } t_action;

    typedef enum logic [3:0] {
        CMD_START         = 4'd0,
        CMD_STOP          = 4'd1,
        CMD_TCP_OPEN      = 4'd2,
        CMD_TCP_CLOSED    = 4'd3,
        CMD_OPEN_FAILED   = 4'd4,
        CMD_FATAL         = 4'd5,
        CMD_RETRY_EXP     = 4'd6,
        CMD_HOLD_EXP      = 4'd7,
        CMD_KEEPALIVE_EXP = 4'd8,
        CMD_RX_OPEN       = 4'd9,
        CMD_RX_KEEPALIVE  = 4'd10,
        CMD_RX_UPDATE     = 4'd11,
        CMD_RX_NOTIFY     = 4'd12
    } t_cmd;

    typedef enum logic [1:0] {
        FOLLOW_NONE        = 2'd0,
        FOLLOW_TCP_OPEN    = 2'd1,
        FOLLOW_OPEN_FAILED = 2'd2
    } t_follow;

    localparam logic [1:0] CRES_SUCCESS = 2'd1;
    localparam logic [1:0] CRES_PENDING = 2'd2;

    localparam logic [2:0] CFG_PASSIVE    = 3'd0;
    localparam logic [2:0] CFG_ADMIN      = 3'd1;
    localparam logic [2:0] CFG_ACCEPTING  = 3'd2;
    localparam logic [2:0] CFG_INIT_START = 3'd3;
    localparam logic [2:0] CFG_HOLD       = 3'd4;

    localparam int          CFG_DATA_W     = 16;
    localparam logic [6:0]  RETRY_CAP      = 7'(60 * 2);
    localparam logic [6:0]  INIT_START_RST = 7'd5;
    localparam logic [15:0] HOLD_TIME_RST  = 16'd180;

    typedef struct packed {
        t_action act;
        t_state  nxt;
    } t_cell;

    typedef struct packed {
        t_state     new_state;
        t_action    action;
        t_follow    follow_event;
        logic       send_open;
        logic       start_timer_on;
        logic       connect_timer_on;
        logic       hold_timer_on;
        logic       hold_timer_restart;
        logic       keepalive_timer_on;
        logic       routeadv_timer_on;
        logic [6:0] start_interval;
        logic       aborted;
    } t_result;

    function automatic logic hold_on_in(input t_state st, input logic [15:0] hold_time);
        return (st == ST_OPEN_SENT || st == ST_OPEN_CONFIRM || st == ST_ESTABLISHED)
            && (hold_time != 16'd0);
    endfunction

    // Transition table: next state and action per state and event.
    function automatic t_cell fsm_lookup(input t_state st, input logic [3:0] cmd);
        t_cell c;
        c.act = ACT_IGNORE;
        c.nxt = ST_IDLE;
        if (cmd > CMD_RX_NOTIFY) begin
            c.nxt = st;
        end else begin
            case (st)
                ST_IDLE: begin
                    case (cmd)
                        CMD_START:      c = '{ACT_START_CONNECT, ST_CONNECT};
                        CMD_STOP, CMD_TCP_OPEN, CMD_TCP_CLOSED, CMD_FATAL:
                                        c = '{ACT_STOP, ST_IDLE};
                        default:        c = '{ACT_IGNORE, ST_IDLE};
                    endcase
                end
                ST_CONNECT: begin
                    case (cmd)
                        CMD_START:       c = '{ACT_IGNORE, ST_CONNECT};
                        CMD_STOP, CMD_TCP_CLOSED, CMD_RX_NOTIFY:
                                         c = '{ACT_STOP, ST_IDLE};
                        CMD_TCP_OPEN:    c = '{ACT_CONNECT_SUCCESS, ST_OPEN_SENT};
                        CMD_OPEN_FAILED: c = '{ACT_CONNECT_FAIL, ST_ACTIVE};
                        CMD_FATAL:       c = '{ACT_CONNECT_FAIL, ST_IDLE};
                        CMD_RETRY_EXP:   c = '{ACT_RECONNECT, ST_CONNECT};
                        default:         c = '{ACT_IGNORE, ST_IDLE};
                    endcase
                end
                ST_ACTIVE: begin
                    case (cmd)
                        CMD_START, CMD_OPEN_FAILED:
                                        c = '{ACT_IGNORE, ST_ACTIVE};
                        CMD_STOP, CMD_TCP_CLOSED:
                                        c = '{ACT_STOP, ST_IDLE};
                        CMD_TCP_OPEN:   c = '{ACT_CONNECT_SUCCESS, ST_OPEN_SENT};
                        CMD_RETRY_EXP:  c = '{ACT_START_CONNECT, ST_CONNECT};
                        CMD_RX_NOTIFY:  c = '{ACT_STOP_ERROR, ST_IDLE};
                        default:        c = '{ACT_IGNORE, ST_IDLE};
                    endcase
                end
                ST_OPEN_SENT: begin
                    case (cmd)
                        CMD_START:      c = '{ACT_IGNORE, ST_OPEN_SENT};
                        CMD_STOP, CMD_TCP_OPEN, CMD_FATAL:
                                        c = '{ACT_STOP, ST_IDLE};
                        CMD_TCP_CLOSED: c = '{ACT_STOP, ST_ACTIVE};
                        CMD_HOLD_EXP:   c = '{ACT_HOLD_EXPIRE, ST_IDLE};
                        CMD_RX_OPEN:    c = '{ACT_OPEN_RECEIVED, ST_OPEN_CONFIRM};
                        CMD_RX_NOTIFY:  c = '{ACT_STOP_ERROR, ST_IDLE};
                        default:        c = '{ACT_IGNORE, ST_IDLE};
                    endcase
                end
                ST_OPEN_CONFIRM: begin
                    case (cmd)
                        CMD_START, CMD_KEEPALIVE_EXP:
                                          c = '{ACT_IGNORE, ST_OPEN_CONFIRM};
                        CMD_STOP, CMD_TCP_OPEN, CMD_TCP_CLOSED, CMD_OPEN_FAILED,
                        CMD_FATAL:        c = '{ACT_STOP, ST_IDLE};
                        CMD_HOLD_EXP:     c = '{ACT_HOLD_EXPIRE, ST_IDLE};
                        CMD_RX_KEEPALIVE: c = '{ACT_ESTABLISH, ST_ESTABLISHED};
                        CMD_RX_NOTIFY:    c = '{ACT_STOP_ERROR, ST_IDLE};
                        default:          c = '{ACT_IGNORE, ST_IDLE};
                    endcase
                end
                ST_ESTABLISHED: begin
                    case (cmd)
                        CMD_START:         c = '{ACT_IGNORE, ST_ESTABLISHED};
                        CMD_STOP, CMD_TCP_OPEN, CMD_TCP_CLOSED, CMD_FATAL,
                        CMD_RX_OPEN:       c = '{ACT_STOP, ST_IDLE};
                        CMD_HOLD_EXP:      c = '{ACT_HOLD_EXPIRE, ST_IDLE};
                        CMD_KEEPALIVE_EXP: c = '{ACT_SEND_KEEPALIVE, ST_ESTABLISHED};
                        CMD_RX_KEEPALIVE:  c = '{ACT_KEEPALIVE_RX, ST_ESTABLISHED};
                        CMD_RX_UPDATE:     c = '{ACT_UPDATE_RX, ST_ESTABLISHED};
                        CMD_RX_NOTIFY:     c = '{ACT_STOP_ERROR, ST_IDLE};
                        default:           c = '{ACT_IGNORE, ST_IDLE};
                    endcase
                end
                default: c = '{ACT_IGNORE, ST_IDLE};
            endcase
        end
        return c;
    endfunction

endpackage

[rtl/core/bgp_session_fsm_unit.sv]
// BGP session state machine, one session event per transaction.
// Input channel: i_in_valid / o_in_stall with i_cmd, i_connect_result and
// i_socket_valid. Output channel: o_out_valid / i_out_stall with the new
// state, action, follow-up event, timer enables, retry interval and abort.
// Every input transaction yields exactly one output transaction.
// Path: input register, then table lookup and update into the result
// register; o_out_valid rises when the result register is loaded.
// Throughput: one transaction per cycle while i_out_stall is low; the
// session state is updated in the same edge that loads the result
// register, so the next event sees it.
// Config: i_cfg_we / i_cfg_addr / i_cfg_data, write only, applied at once;
// write only while the block is empty.
// Reset (synchronous, i_rst_n low): both stages empty, state Idle, retry
// interval 5, config registers at their reset values.
// Receiver stall: the result register holds; the input register keeps
// accepting until it is full, then o_in_stall rises.
`include "assert_macros.svh"

module bgp_session_fsm_unit (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [2:0]                        i_cfg_addr,
    input  logic [bsf_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    input  logic                              i_in_valid,
    output logic                              o_in_stall,
    input  logic [3:0]                        i_cmd,
    input  logic [1:0]                        i_connect_result,
    input  logic                              i_socket_valid,
    output logic                              o_out_valid,
    input  logic                              i_out_stall,
    output logic [2:0]                        o_new_state,
    output logic [3:0]                        o_action,
    output logic [1:0]                        o_follow_event,
    output logic                              o_send_open,
    output logic                              o_start_timer_on,
    output logic                              o_connect_timer_on,
    output logic                              o_hold_timer_on,
    output logic                              o_hold_timer_restart,
    output logic                              o_keepalive_timer_on,
    output logic                              o_routeadv_timer_on,
    output logic [6:0]                        o_start_interval,
    output logic                              o_aborted
);

    logic        r_passive;
    logic        r_admin;
    logic        r_accepting;
    logic [6:0]  r_init_start;
    logic [15:0] r_hold_time;

    logic        r_in_valid;
    logic [3:0]  r_in_cmd;
    logic [1:0]  r_in_cres;
    logic        r_in_sock;

    bsf_pkg::t_state  r_state;
    bsf_pkg::t_state  n_state;
    logic [6:0]       r_retry;
    logic [6:0]       n_retry;
    logic             r_routeadv;
    logic             n_routeadv;

    logic             r_out_valid;
    bsf_pkg::t_result r_res;
    bsf_pkg::t_result n_res;

    bsf_pkg::t_cell   entry;
    bsf_pkg::t_follow follow;
    logic             send_open;
    logic             abort_ev;
    logic [7:0]       retry_dbl;
    logic             before_hold;
    logic             hold_on;

    logic out_free;
    logic fire;
    logic in_free;

    assign out_free   = !r_out_valid || !i_out_stall;
    assign fire       = r_in_valid && out_free;
    assign in_free    = !r_in_valid || fire;
    assign o_in_stall = !in_free;

    // Configuration registers; keepalive time drives no output and is not kept.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_passive    <= 1'b0;
            r_admin      <= 1'b1;
            r_accepting  <= 1'b0;
            r_init_start <= bsf_pkg::INIT_START_RST;
            r_hold_time  <= bsf_pkg::HOLD_TIME_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                bsf_pkg::CFG_PASSIVE:    r_passive    <= i_cfg_data[0];
                bsf_pkg::CFG_ADMIN:      r_admin      <= i_cfg_data[0];
                bsf_pkg::CFG_ACCEPTING:  r_accepting  <= i_cfg_data[0];
                bsf_pkg::CFG_INIT_START: r_init_start <= i_cfg_data[6:0];
                bsf_pkg::CFG_HOLD:       r_hold_time  <= i_cfg_data[15:0];
                default: ;
            endcase
        end
    end

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_free) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_free && i_in_valid) begin
            r_in_cmd  <= i_cmd;
            r_in_cres <= i_connect_result;
            r_in_sock <= i_socket_valid;
        end
    end

    // Next state, action and session variables
    always_comb begin
        entry     = bsf_pkg::fsm_lookup(r_state, r_in_cmd);
        follow    = bsf_pkg::FOLLOW_NONE;
        send_open = 1'b0;
        abort_ev  = 1'b0;
        n_retry   = r_retry;
        retry_dbl = {r_retry, 1'b0};
        case (entry.act)
            bsf_pkg::ACT_START_CONNECT, bsf_pkg::ACT_RECONNECT: begin
                if (r_passive) begin
                    follow = bsf_pkg::FOLLOW_OPEN_FAILED;
                end else if (r_in_cres == bsf_pkg::CRES_SUCCESS) begin
                    follow = bsf_pkg::FOLLOW_TCP_OPEN;
                end else if (r_in_cres == bsf_pkg::CRES_PENDING) begin
                    abort_ev = !r_in_sock && (entry.act == bsf_pkg::ACT_START_CONNECT);
                end else begin
                    follow = bsf_pkg::FOLLOW_OPEN_FAILED;
                end
            end
            bsf_pkg::ACT_STOP_ERROR: begin
                n_retry = (retry_dbl >= {1'b0, bsf_pkg::RETRY_CAP}) ?
                          bsf_pkg::RETRY_CAP : retry_dbl[6:0];
            end
            bsf_pkg::ACT_CONNECT_SUCCESS: begin
                abort_ev  = !r_in_sock;
                send_open = r_in_sock && !r_accepting;
            end
            bsf_pkg::ACT_ESTABLISH: begin
                n_retry = r_init_start;
            end
            bsf_pkg::ACT_HOLD_EXPIRE: begin
                abort_ev = r_accepting;
            end
            default: ;
        endcase

        if (abort_ev) begin
            n_state    = r_state;
            follow     = bsf_pkg::FOLLOW_NONE;
            send_open  = 1'b0;
            n_routeadv = r_routeadv;
        end else begin
            n_state = entry.nxt;
            if (entry.nxt != bsf_pkg::ST_ESTABLISHED) begin
                n_routeadv = 1'b0;
            end else if (entry.act == bsf_pkg::ACT_ESTABLISH) begin
                n_routeadv = 1'b1;
            end else begin
                n_routeadv = r_routeadv;
            end
        end
    end

    // Result fields
    always_comb begin
        before_hold = bsf_pkg::hold_on_in(r_state, r_hold_time);
        hold_on     = bsf_pkg::hold_on_in(n_state, r_hold_time);

        n_res.new_state          = n_state;
        n_res.action             = entry.act;
        n_res.follow_event       = follow;
        n_res.send_open          = send_open;
        n_res.start_timer_on     = (n_state == bsf_pkg::ST_IDLE) && r_admin;
        n_res.connect_timer_on   = (n_state == bsf_pkg::ST_CONNECT) ||
                                   ((n_state == bsf_pkg::ST_ACTIVE) && !r_passive);
        n_res.hold_timer_on      = hold_on;
        n_res.hold_timer_restart = !abort_ev && hold_on &&
                                   (!before_hold ||
                                    entry.act == bsf_pkg::ACT_OPEN_RECEIVED ||
                                    entry.act == bsf_pkg::ACT_KEEPALIVE_RX ||
                                    entry.act == bsf_pkg::ACT_UPDATE_RX);
        n_res.keepalive_timer_on = ((n_state == bsf_pkg::ST_OPEN_CONFIRM) ||
                                    (n_state == bsf_pkg::ST_ESTABLISHED)) &&
                                   (r_hold_time != 16'd0);
        n_res.routeadv_timer_on  = n_routeadv;
        n_res.start_interval     = n_retry;
        n_res.aborted            = abort_ev;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= bsf_pkg::ST_IDLE;
            r_retry    <= bsf_pkg::INIT_START_RST;
            r_routeadv <= 1'b0;
        end else if (fire) begin
            r_state    <= n_state;
            r_retry    <= n_retry;
            r_routeadv <= n_routeadv;
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= fire;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_res <= n_res;
        end
    end

    assign o_out_valid          = r_out_valid;
    assign o_new_state          = r_res.new_state;
    assign o_action             = r_res.action;
    assign o_follow_event       = r_res.follow_event;
    assign o_send_open          = r_res.send_open;
    assign o_start_timer_on     = r_res.start_timer_on;
    assign o_connect_timer_on   = r_res.connect_timer_on;
    assign o_hold_timer_on      = r_res.hold_timer_on;
    assign o_hold_timer_restart = r_res.hold_timer_restart;
    assign o_keepalive_timer_on = r_res.keepalive_timer_on;
    assign o_routeadv_timer_on  = r_res.routeadv_timer_on;
    assign o_start_interval     = r_res.start_interval;
    assign o_aborted            = r_res.aborted;

    `ASSERT_ALWAYS(a_routeadv_only_est, i_clk, i_rst_n, !r_routeadv || (r_state == bsf_pkg::ST_ESTABLISHED))
    `ASSERT_NEXT(a_abort_keeps_state, i_clk, i_rst_n, fire && abort_ev, $stable(r_state))
    `ASSERT_NEXT(a_state_moves_on_fire, i_clk, i_rst_n, !fire, $stable(r_state) && $stable(r_retry))
    `ASSERT_NEXT(a_in_item_held, i_clk, i_rst_n, r_in_valid && !fire, r_in_valid)

endmodule
